>>> design/ctar_pkg.sv
// Shared widths, register indexes, arctangent table and output scaling
// for the three-axis CORDIC rotator. No dependencies.
`default_nettype none

package ctar_pkg;

    localparam int DATA_W  = 16;   // point coordinate width
    localparam int ANGLE_W = 11;   // angle width, 2048 steps per turn
    localparam int QUAD_W  = 2;    // quadrant bits at the top of the angle
    localparam int RESID_W = ANGLE_W - QUAD_W;
    localparam int RES_W   = 12;   // signed residue accumulator, holds -2048..2047
    localparam int ITER_W  = 4;    // iteration count register width
    localparam int CFG_W   = ANGLE_W;
    localparam int CFG_IDX_W = 2;

    localparam int ROM_SIZE = 12;
    localparam int MAX_ITERATIONS_DEF = 9;
    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(9);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_THIRD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_COUNT   = 2'd3;

    // quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;

    // atan(2^-i) in units of 1/2048 turn
    function automatic logic signed [RES_W-1:0] atan_rom(input int idx);
        case (idx)
            0:       atan_rom = RES_W'(256);
            1:       atan_rom = RES_W'(151);
            2:       atan_rom = RES_W'(80);
            3:       atan_rom = RES_W'(41);
            4:       atan_rom = RES_W'(20);
            5:       atan_rom = RES_W'(10);
            6:       atan_rom = RES_W'(5);
            7:       atan_rom = RES_W'(3);
            8:       atan_rom = RES_W'(1);
            9:       atan_rom = RES_W'(1);
            default: atan_rom = RES_W'(0);
        endcase
    endfunction

    // gain correction, about 0.59375
    function automatic logic signed [DATA_W-1:0] gain_scale(
        input logic signed [DATA_W-1:0] e);
        gain_scale = (e >>> 1) + (e >>> 4) + (e >>> 5);
    endfunction

endpackage

`default_nettype wire

>>> design/ctar_rot.sv
// One pipelined CORDIC rotation: quadrant pre-rotation, one register per
// micro-rotation, then gain scaling. Carries one side value alongside. Uses ctar_pkg.
`default_nettype none

module ctar_rot #(
    parameter int MAX_ITER = ctar_pkg::MAX_ITERATIONS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic signed [ctar_pkg::DATA_W-1:0]   i_a,
    input  wire logic signed [ctar_pkg::DATA_W-1:0]   i_b,
    input  wire logic signed [ctar_pkg::DATA_W-1:0]   i_side,
    input  wire logic        [ctar_pkg::ANGLE_W-1:0]  i_angle,
    input  wire logic        [ctar_pkg::ITER_W-1:0]   i_iters,
    output logic                                      o_valid,
    output logic signed      [ctar_pkg::DATA_W-1:0]   o_a,
    output logic signed      [ctar_pkg::DATA_W-1:0]   o_b,
    output logic signed      [ctar_pkg::DATA_W-1:0]   o_side
);
    import ctar_pkg::*;

    logic                      r_v [0:MAX_ITER];
    logic signed [DATA_W-1:0]  r_x [0:MAX_ITER];
    logic signed [DATA_W-1:0]  r_y [0:MAX_ITER];
    logic signed [RES_W-1:0]   r_r [0:MAX_ITER];
    logic signed [DATA_W-1:0]  r_s [0:MAX_ITER];

    logic signed [DATA_W-1:0]  n_x [0:MAX_ITER-1];
    logic signed [DATA_W-1:0]  n_y [0:MAX_ITER-1];
    logic signed [RES_W-1:0]   n_r [0:MAX_ITER-1];

    logic signed [DATA_W-1:0]  n_x0;
    logic signed [DATA_W-1:0]  n_y0;
    logic signed [RES_W-1:0]   n_r0;

    logic                      r_out_v;
    logic signed [DATA_W-1:0]  r_out_a;
    logic signed [DATA_W-1:0]  r_out_b;
    logic signed [DATA_W-1:0]  r_out_s;

    // 90-degree pre-rotation; negation wraps at 16 bits
    always_comb begin
        n_r0 = RES_W'(i_angle[RESID_W-1:0]);
        case (i_angle[ANGLE_W-1 -: QUAD_W])
            QUAD_0: begin n_x0 = i_a;  n_y0 = i_b;  end
            QUAD_1: begin n_x0 = i_b;  n_y0 = -i_a; end
            QUAD_2: begin n_x0 = -i_a; n_y0 = -i_b; end
            default: begin n_x0 = -i_b; n_y0 = i_a; end
        endcase
    end

    for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
        localparam logic signed [RES_W-1:0] T = atan_rom(k);
        logic act;
        logic neg;
        assign act = i_iters > ITER_W'(k);
        assign neg = r_r[k][RES_W-1];
        assign n_x[k] = !act ? r_x[k] :
                        neg  ? r_x[k] - (r_y[k] >>> k) : r_x[k] + (r_y[k] >>> k);
        assign n_y[k] = !act ? r_y[k] :
                        neg  ? r_y[k] + (r_x[k] >>> k) : r_y[k] - (r_x[k] >>> k);
        assign n_r[k] = !act ? r_r[k] :
                        neg  ? r_r[k] + T : r_r[k] - T;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAX_ITER; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < MAX_ITER; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_out_v <= r_v[MAX_ITER];
        end
        r_x[0] <= n_x0;
        r_y[0] <= n_y0;
        r_r[0] <= n_r0;
        r_s[0] <= i_side;
        for (int k = 0; k < MAX_ITER; k++) begin
            r_x[k+1] <= n_x[k];
            r_y[k+1] <= n_y[k];
            r_r[k+1] <= n_r[k];
            r_s[k+1] <= r_s[k];
        end
        r_out_a <= gain_scale(r_x[MAX_ITER]);
        r_out_b <= gain_scale(r_y[MAX_ITER]);
        r_out_s <= r_s[MAX_ITER];
    end

    assign o_valid = r_out_v;
    assign o_a     = r_out_a;
    assign o_b     = r_out_b;
    assign o_side  = r_out_s;

endmodule

`default_nettype wire

>>> design/cordic_three_axis_rotator_top.sv
// Three-axis CORDIC point rotator: three chained rotation pipelines.
// Each point passes the three units in turn from start to o_valid;
// one point per cycle, each rotation unit has one register per micro-rotation.
// busy stays low; results come one cycle each on o_valid and cannot be stalled.
// Synchronous active-low reset clears valid bits and loads register defaults.
`default_nettype none

module cordic_three_axis_rotator_top #(
    parameter int MAX_ITERATIONS = ctar_pkg::MAX_ITERATIONS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [ctar_pkg::DATA_W-1:0]    i_in_x,
    input  wire logic signed [ctar_pkg::DATA_W-1:0]    i_in_y,
    input  wire logic signed [ctar_pkg::DATA_W-1:0]    i_in_z,
    input  wire logic                                  i_cfg_we,
    input  wire logic        [ctar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic        [ctar_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                       o_valid,
    output logic signed      [ctar_pkg::DATA_W-1:0]    o_out_x,
    output logic signed      [ctar_pkg::DATA_W-1:0]    o_out_y,
    output logic signed      [ctar_pkg::DATA_W-1:0]    o_out_z
);
    import ctar_pkg::*;

    localparam int LAT_ROT = MAX_ITERATIONS + 2;
    localparam logic [ITER_W-1:0] ITER_MAX = ITER_W'(MAX_ITERATIONS);

    logic [ANGLE_W-1:0] r_angle_first;
    logic [ANGLE_W-1:0] r_angle_second;
    logic [ANGLE_W-1:0] r_angle_third;
    logic [ITER_W-1:0]  r_iter_cnt;
    logic [ITER_W-1:0]  iters_eff;

    logic                     accept;
    logic                     s1_valid, s2_valid;
    logic signed [DATA_W-1:0] s1_x, s1_y, s1_px;
    logic signed [DATA_W-1:0] s2_x, s2_y, s2_s1x;
    logic signed [DATA_W-1:0] s3_x, s3_y;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_first  <= '0;
            r_angle_second <= '0;
            r_angle_third  <= '0;
            r_iter_cnt     <= ITER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ANGLE_FIRST:  r_angle_first  <= i_cfg_data;
                CFG_ANGLE_SECOND: r_angle_second <= i_cfg_data;
                CFG_ANGLE_THIRD:  r_angle_third  <= i_cfg_data;
                CFG_ITER_COUNT:   r_iter_cnt     <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to 1..MAX_ITERATIONS
    always_comb begin
        if (r_iter_cnt == '0) begin
            iters_eff = ITER_W'(1);
        end else if (r_iter_cnt > ITER_MAX) begin
            iters_eff = ITER_MAX;
        end else begin
            iters_eff = r_iter_cnt;
        end
    end

    // stage 1 rotates (y, z); x rides along
    ctar_rot #(.MAX_ITER(MAX_ITERATIONS)) u_rot1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_a     (i_in_y),
        .i_b     (i_in_z),
        .i_side  (i_in_x),
        .i_angle (r_angle_first),
        .i_iters (iters_eff),
        .o_valid (s1_valid),
        .o_a     (s1_x),
        .o_b     (s1_y),
        .o_side  (s1_px)
    );

    // stage 2 rotates (s1.y, x); s1.x rides along
    ctar_rot #(.MAX_ITER(MAX_ITERATIONS)) u_rot2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_a     (s1_y),
        .i_b     (s1_px),
        .i_side  (s1_x),
        .i_angle (r_angle_second),
        .i_iters (iters_eff),
        .o_valid (s2_valid),
        .o_a     (s2_x),
        .o_b     (s2_y),
        .o_side  (s2_s1x)
    );

    // stage 3 rotates (s2.y, s1.x); s2.x rides along as out_z
    ctar_rot #(.MAX_ITER(MAX_ITERATIONS)) u_rot3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_a     (s2_y),
        .i_b     (s2_s1x),
        .i_side  (s2_x),
        .i_angle (r_angle_third),
        .i_iters (iters_eff),
        .o_valid (o_valid),
        .o_a     (s3_x),
        .o_b     (s3_y),
        .o_side  (o_out_z)
    );

    assign o_out_x = s3_x;
    assign o_out_y = s3_y;

    // a result beat only follows an accepted point by the full latency
    a_out_follows_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 3 * LAT_ROT))
        else $error("result beat without matching input beat");

    a_s2_follows_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid |-> $past(s1_valid, LAT_ROT))
        else $error("stage 2 beat without stage 1 beat");

    a_iters_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (iters_eff != '0) && (iters_eff <= ITER_MAX))
        else $error("effective iteration count out of range");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the three-axis CORDIC point rotator.
// Directed rows, then random points under changing angle/iteration settings,
// checked against a local bit-exact predictor or typed values. Depends on ctar_pkg and the top.
`default_nettype none

module tb_top;
    import ctar_pkg::*;

    localparam int LATENCY     = 3 * (MAX_ITERATIONS_DEF + 2);
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_PTS   = 100;
    localparam int N_DIR       = 26;
    localparam int ATAN_STEPS [ROM_SIZE] = '{256, 151, 80, 41, 20, 10, 5, 3, 1, 1, 0, 0};

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_point;

    typedef enum logic {ROW_PT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        t_point                 pt;
        bit                     typed;
        t_point                 want;
    } t_dir_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [DATA_W-1:0]   i_in_x = '0;
    logic signed [DATA_W-1:0]   i_in_y = '0;
    logic signed [DATA_W-1:0]   i_in_z = '0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       o_valid;
    logic signed [DATA_W-1:0]   o_out_x;
    logic signed [DATA_W-1:0]   o_out_y;
    logic signed [DATA_W-1:0]   o_out_z;

    // shadow copy of the configuration registers
    logic [ANGLE_W-1:0] angle_1st = '0;
    logic [ANGLE_W-1:0] angle_2nd = '0;
    logic [ANGLE_W-1:0] angle_3rd = '0;
    logic [ITER_W-1:0]  iter_reg  = ITER_RESET;

    t_point expected_points [$];
    int     mismatches = 0;
    int     cycles = 0;

    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{0, 0, 0},                1'b1, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{32767, 32767, 32767},    1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{-32768, -32768, -32768}, 1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{1, -1, 0},               1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{100, -200, 300},         1'b0, '{0, 0, 0}},
        // zero iterations behaves as one
        '{ROW_CFG, CFG_ITER_COUNT,   11'd0,    '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{32767, -32768, 12345},   1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{0, 0, 0},                1'b1, '{0, 0, 0}},
        // above the maximum saturates
        '{ROW_CFG, CFG_ITER_COUNT,   11'd15,   '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{-32768, 32767, -1},      1'b0, '{0, 0, 0}},
        '{ROW_CFG, CFG_ITER_COUNT,   11'd9,    '{0, 0, 0},                1'b0, '{0, 0, 0}},
        // quadrants 2, 1, 3: pre-rotation negates, -32768 wraps
        '{ROW_CFG, CFG_ANGLE_FIRST,  11'd1024, '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_CFG, CFG_ANGLE_SECOND, 11'd512,  '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_CFG, CFG_ANGLE_THIRD,  11'd1536, '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{-32768, -32768, -32768}, 1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{32767, 32767, -32768},   1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{0, 0, 0},                1'b1, '{0, 0, 0}},
        '{ROW_CFG, CFG_ANGLE_FIRST,  11'd2047, '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_CFG, CFG_ANGLE_SECOND, 11'd511,  '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_CFG, CFG_ANGLE_THIRD,  11'd1,    '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{32767, -32768, 32767},   1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{-1, -1, -1},             1'b0, '{0, 0, 0}},
        '{ROW_CFG, CFG_ITER_COUNT,   11'd1,    '{0, 0, 0},                1'b0, '{0, 0, 0}},
        // large sums wrap at 16 bits
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{20000, -20000, 30000},   1'b0, '{0, 0, 0}},
        // upper data bits above the 4-bit count are dropped
        '{ROW_CFG, CFG_ITER_COUNT,   11'h7F9,  '{0, 0, 0},                1'b0, '{0, 0, 0}},
        '{ROW_PT,  CFG_ANGLE_FIRST,  11'd0,    '{1, 2, 3},                1'b0, '{0, 0, 0}}
    };

    cordic_three_axis_rotator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_x     (i_in_x),
        .i_in_y     (i_in_y),
        .i_in_z     (i_in_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z)
    );

    always #5 i_clk = ~i_clk;

    // one CORDIC stage: quadrant pre-rotation, n micro-rotations, gain trim
    function automatic void rotate_pair(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b,
                                        input logic [ANGLE_W-1:0] ang,
                                        input int n,
                                        output logic signed [DATA_W-1:0] ra,
                                        output logic signed [DATA_W-1:0] rb);
        logic signed [DATA_W-1:0] x, y, nx, ny;
        int resid;
        case (ang[ANGLE_W-1:RESID_W])
            QUAD_0: begin x = a;  y = b;  end
            QUAD_1: begin x = b;  y = -a; end
            QUAD_2: begin x = -a; y = -b; end
            default: begin x = -b; y = a; end
        endcase
        resid = int'(ang[RESID_W-1:0]);
        for (int i = 0; i < n; i++) begin
            if (resid < 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                resid += ATAN_STEPS[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                resid -= ATAN_STEPS[i];
            end
            x = nx;
            y = ny;
        end
        ra = (x >>> 1) + (x >>> 4) + (x >>> 5);
        rb = (y >>> 1) + (y >>> 4) + (y >>> 5);
    endfunction

    function automatic t_point predict_point(input t_point p);
        logic signed [DATA_W-1:0] s1x, s1y, s2x, s2y, s3x, s3y;
        int n;
        n = (iter_reg == 0) ? 1 :
            (iter_reg > MAX_ITERATIONS_DEF) ? MAX_ITERATIONS_DEF : int'(iter_reg);
        rotate_pair(p.y, p.z, angle_1st, n, s1x, s1y);
        rotate_pair(s1y, p.x, angle_2nd, n, s2x, s2y);
        rotate_pair(s2y, s1x, angle_3rd, n, s3x, s3y);
        return '{s3x, s3y, s2x};
    endfunction

    function automatic logic signed [DATA_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return -16'sd1;
            4:       return DATA_W'($urandom_range(0, 255)) - 16'sd128;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] random_angle();
        case ($urandom_range(0, 3))
            0:       return {QUAD_W'($urandom_range(0, 3)), {RESID_W{1'b0}}};
            1:       return {QUAD_W'($urandom_range(0, 3)), {RESID_W{1'b1}}};
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    // called right after posedge i_clk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ANGLE_FIRST:  angle_1st = data[ANGLE_W-1:0];
            CFG_ANGLE_SECOND: angle_2nd = data[ANGLE_W-1:0];
            CFG_ANGLE_THIRD:  angle_3rd = data[ANGLE_W-1:0];
            default:          iter_reg  = data[ITER_W-1:0];
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // start stays high on return so back-to-back beats need no gap
    task automatic send_point(input t_point p, input bit typed, input t_point want);
        t_point exp_pt;
        start  <= 1'b1;
        i_in_x <= p.x;
        i_in_y <= p.y;
        i_in_z <= p.z;
        do
            @(posedge i_clk);
        while (busy);
        exp_pt = typed ? want : predict_point(p);
        expected_points = {expected_points, exp_pt};
    endtask

    always @(posedge i_clk) begin
        t_point got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (i_rst_n && o_valid) begin
            got = '{o_out_x, o_out_y, o_out_z};
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            end else begin
                want = expected_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                 want.x, want.y, want.z, got.x, got.y, got.z);
                end
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] iter_data;
        bit burst;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                hold_off($urandom_range(0, 5));
                send_point(dir_rows[r].pt, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            iter_data = CFG_W'($urandom);
            case (phase)
                0: begin
                    write_reg(CFG_ANGLE_FIRST, '0);
                    write_reg(CFG_ANGLE_SECOND, '0);
                    write_reg(CFG_ANGLE_THIRD, '0);
                    iter_data[ITER_W-1:0] = ITER_W'(MAX_ITERATIONS_DEF);
                end
                1: begin
                    write_reg(CFG_ANGLE_FIRST, CFG_W'(2047));
                    write_reg(CFG_ANGLE_SECOND, CFG_W'(2047));
                    write_reg(CFG_ANGLE_THIRD, CFG_W'(2047));
                    iter_data[ITER_W-1:0] = ITER_W'(1);
                end
                default: begin
                    write_reg(CFG_ANGLE_FIRST, random_angle());
                    write_reg(CFG_ANGLE_SECOND, random_angle());
                    write_reg(CFG_ANGLE_THIRD, random_angle());
                    if (phase == 2)
                        iter_data[ITER_W-1:0] = '0;
                    else if (phase == 3)
                        iter_data[ITER_W-1:0] = '1;
                    else if (phase % 2 == 0)
                        iter_data[ITER_W-1:0] = ITER_W'($urandom_range(1, 9));
                end
            endcase
            write_reg(CFG_ITER_COUNT, iter_data);

            burst = 1'b0;
            for (int k = 0; k < PHASE_PTS; k++) begin
                if ($urandom_range(0, 19) == 0)
                    burst = !burst;
                // let the pipeline run dry once mid-phase
                if (phase == 4 && k == PHASE_PTS / 2)
                    wait_drained();
                hold_off(burst ? 0 : $urandom_range(0, 5));
                send_point('{random_coord(), random_coord(), random_coord()}, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> cordic_three_axis_rotator_top.f
design/ctar_pkg.sv
design/ctar_rot.sv
design/cordic_three_axis_rotator_top.sv
dv/tb_top.sv
